>>> src/lfms_pkg.sv
// lfms_pkg: shared types, constants and helper functions of the line follower motor sequencer
// used by every module under src and by the checker; no dependencies
`timescale 1ns / 1ps

package lfms_pkg;

	localparam int TICK_W  = 16;
	localparam int BAL_W   = 16;
	localparam int DELTA_W = 5;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int DRIVE_W = 3;
	localparam int PAT_W   = 5;
	localparam int IN_W    = 8;
	localparam int OUT_W   = 8;

	localparam logic [TICK_W-1:0] LONG_TICKS_RST  = TICK_W'(250);
	localparam logic [TICK_W-1:0] PROBE_TICKS_RST = TICK_W'(10);
	localparam logic [TICK_W-1:0] TURN_TICKS_RST  = TICK_W'(100);

	localparam logic signed [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
	localparam logic signed [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

	// balance steps; the loop deltas are what a stalled decide loop does in one tick
	localparam logic signed [DELTA_W-1:0] D_NONE       = DELTA_W'(0);
	localparam logic signed [DELTA_W-1:0] D_INC1       = DELTA_W'(1);
	localparam logic signed [DELTA_W-1:0] D_DEC1       = -DELTA_W'(1);
	localparam logic signed [DELTA_W-1:0] D_DEC_LOOP   = -DELTA_W'(5);
	localparam logic signed [DELTA_W-1:0] D_INC_LOOP   = DELTA_W'(8);
	localparam logic signed [DELTA_W-1:0] D_INC_LOOP_S = DELTA_W'(7);

	typedef enum logic [IDX_W-1:0] {
		REG_LONG_TICKS  = 2'd0,
		REG_PROBE_TICKS = 2'd1,
		REG_TURN_TICKS  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_DECIDE    = 3'd0,
		PH_PROBE     = 3'd1,
		PH_REVERSE   = 3'd2,
		PH_REC_LEFT  = 3'd3,
		PH_REC_RIGHT = 3'd4,
		PH_STOP      = 3'd5,
		PH_LEFT      = 3'd6,
		PH_RIGHT     = 3'd7
	} phase_t;

	typedef enum logic [DRIVE_W-1:0] {
		CMD_STOP  = 3'd0,
		CMD_FWD   = 3'd1,
		CMD_REV   = 3'd2,
		CMD_LEFT  = 3'd3,
		CMD_RIGHT = 3'd4
	} cmd_t;

	localparam logic [PAT_W-1:0] PAT_STOP  = 5'h00;
	localparam logic [PAT_W-1:0] PAT_FWD   = 5'h1C;
	localparam logic [PAT_W-1:0] PAT_REV   = 5'h16;
	localparam logic [PAT_W-1:0] PAT_LEFT  = 5'h1E;
	localparam logic [PAT_W-1:0] PAT_RIGHT = 5'h14;

	typedef struct packed {
		logic [TICK_W-1:0] long_ticks;
		logic [TICK_W-1:0] probe_ticks;
		logic [TICK_W-1:0] turn_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t                   phase;
		logic [TICK_W-1:0]        ticks;
		logic signed [BAL_W-1:0]  bal;
		logic                     resume;
	} state_t;

	function automatic logic signed [BAL_W-1:0] sat_add(
		input logic signed [BAL_W-1:0]   b,
		input logic signed [DELTA_W-1:0] d
	);
		logic signed [BAL_W:0] s;
		s = (BAL_W+1)'(b) + (BAL_W+1)'(d);
		if (s[BAL_W] != s[BAL_W-1]) begin
			return s[BAL_W] ? BAL_MIN : BAL_MAX;
		end
		return s[BAL_W-1:0];
	endfunction

	function automatic cmd_t phase_cmd(input phase_t ph);
		cmd_t c;
		case (ph)
			PH_PROBE:     c = CMD_FWD;
			PH_REVERSE:   c = CMD_REV;
			PH_REC_LEFT:  c = CMD_LEFT;
			PH_REC_RIGHT: c = CMD_RIGHT;
			PH_LEFT:      c = CMD_LEFT;
			PH_RIGHT:     c = CMD_RIGHT;
			default:      c = CMD_STOP;
		endcase
		return c;
	endfunction

	function automatic logic [PAT_W-1:0] pattern_of(input cmd_t c);
		logic [PAT_W-1:0] p;
		case (c)
			CMD_FWD:   p = PAT_FWD;
			CMD_REV:   p = PAT_REV;
			CMD_LEFT:  p = PAT_LEFT;
			CMD_RIGHT: p = PAT_RIGHT;
			default:   p = PAT_STOP;
		endcase
		return p;
	endfunction

endpackage

>>> src/lfms_cfg_regs.sv
// lfms_cfg_regs: the three tick count registers behind the plain write port
// depends on lfms_pkg
`timescale 1ns / 1ps

module lfms_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lfms_pkg::IDX_W-1:0] cfg_index,
	input  logic [lfms_pkg::CFG_W-1:0] cfg_data,
	output lfms_pkg::cfg_t             cfg
);

	lfms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_ticks  <= lfms_pkg::LONG_TICKS_RST;
			cfg_q.probe_ticks <= lfms_pkg::PROBE_TICKS_RST;
			cfg_q.turn_ticks  <= lfms_pkg::TURN_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lfms_pkg::REG_LONG_TICKS:  cfg_q.long_ticks  <= cfg_data;
				lfms_pkg::REG_PROBE_TICKS: cfg_q.probe_ticks <= cfg_data;
				lfms_pkg::REG_TURN_TICKS:  cfg_q.turn_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/lfms_step.sv
// lfms_step: one tick of the phase sequencer, next state and motor command
// depends on lfms_pkg; purely combinational, registered by the top level
`timescale 1ns / 1ps

module lfms_step (
	input  logic                         sensor_left,
	input  logic                         sensor_right,
	input  lfms_pkg::cfg_t               cfg,
	input  lfms_pkg::state_t             cur,
	output lfms_pkg::state_t             nxt,
	output logic [lfms_pkg::DRIVE_W-1:0] drive,
	output logic [lfms_pkg::PAT_W-1:0]   motor_pattern
);

	lfms_pkg::cmd_t                    cmd;
	logic                              lost;
	logic                              both;
	logic                              go_dec;
	logic                              lturn;
	logic                              rec;
	logic [1:0]                        k;
	logic signed [lfms_pkg::BAL_W-1:0] b1;

	assign lost = !sensor_left && !sensor_right;
	assign both = sensor_left && sensor_right;

	// next state; k counts passes spent before reaching the decide phase
	always_comb begin
		nxt    = cur;
		cmd    = lfms_pkg::CMD_STOP;
		go_dec = 1'b0;
		lturn  = 1'b0;
		rec    = 1'b0;
		k      = 2'd0;
		b1     = cur.bal;

		if (cur.phase != lfms_pkg::PH_DECIDE && cur.ticks != '0) begin
			nxt.ticks = cur.ticks - lfms_pkg::TICK_W'(1);
			cmd       = lfms_pkg::phase_cmd(cur.phase);
		end else begin
			case (cur.phase)
				lfms_pkg::PH_DECIDE: begin
					go_dec = 1'b1;
				end
				lfms_pkg::PH_PROBE: begin
					if (lost) begin
						if (cfg.long_ticks != '0) begin
							nxt.phase = lfms_pkg::PH_REVERSE;
							nxt.ticks = cfg.long_ticks - lfms_pkg::TICK_W'(1);
							cmd       = lfms_pkg::CMD_REV;
						end else begin
							rec = 1'b1;
						end
					end else if (cur.resume) begin
						lturn = 1'b1;
					end else begin
						go_dec = 1'b1;
						k      = 2'd1;
					end
				end
				lfms_pkg::PH_REVERSE: begin
					rec = 1'b1;
				end
				lfms_pkg::PH_REC_LEFT, lfms_pkg::PH_REC_RIGHT: begin
					nxt.phase = lfms_pkg::PH_STOP;
					nxt.ticks = '0;
				end
				lfms_pkg::PH_STOP: begin
					if (cur.resume) begin
						lturn = 1'b1;
					end else begin
						go_dec = 1'b1;
						k      = 2'd1;
					end
				end
				default: begin
					go_dec = 1'b1;
					k      = 2'd1;
				end
			endcase
		end

		if (lturn) begin
			b1         = lfms_pkg::sat_add(cur.bal, lfms_pkg::D_DEC1);
			nxt.bal    = b1;
			nxt.resume = 1'b0;
			if (cfg.turn_ticks != '0) begin
				nxt.phase = lfms_pkg::PH_LEFT;
				nxt.ticks = cfg.turn_ticks - lfms_pkg::TICK_W'(1);
				cmd       = lfms_pkg::CMD_LEFT;
			end else begin
				go_dec = 1'b1;
				k      = 2'd2;
			end
		end

		if (go_dec) begin
			nxt.phase = lfms_pkg::PH_DECIDE;
			nxt.ticks = '0;
			if (both) begin
				cmd = lfms_pkg::CMD_FWD;
			end else if (lost) begin
				nxt.resume = 1'b0;
				if (cfg.long_ticks != '0) begin
					nxt.phase = lfms_pkg::PH_PROBE;
					nxt.ticks = cfg.long_ticks - lfms_pkg::TICK_W'(1);
					cmd       = lfms_pkg::CMD_FWD;
				end else begin
					rec = 1'b1;
				end
			end else if (sensor_left) begin
				nxt.resume = 1'b1;
				if (cfg.probe_ticks != '0) begin
					nxt.phase = lfms_pkg::PH_PROBE;
					nxt.ticks = cfg.probe_ticks - lfms_pkg::TICK_W'(1);
					cmd       = lfms_pkg::CMD_FWD;
				end else if (cfg.turn_ticks != '0) begin
					nxt.bal    = lfms_pkg::sat_add(b1, lfms_pkg::D_DEC1);
					nxt.resume = 1'b0;
					nxt.phase  = lfms_pkg::PH_LEFT;
					nxt.ticks  = cfg.turn_ticks - lfms_pkg::TICK_W'(1);
					cmd        = lfms_pkg::CMD_LEFT;
				end else begin
					// probe and turn both empty: the decide loop spins out the tick
					nxt.bal = lfms_pkg::sat_add(b1, lfms_pkg::D_DEC_LOOP);
					case (k)
						2'd0: begin
							nxt.phase  = lfms_pkg::PH_PROBE;
							nxt.resume = 1'b1;
						end
						2'd1: begin
							nxt.phase  = lfms_pkg::PH_DECIDE;
							nxt.resume = 1'b0;
						end
						default: begin
							nxt.phase  = lfms_pkg::PH_LEFT;
							nxt.resume = 1'b0;
						end
					endcase
				end
			end else begin
				if (cfg.turn_ticks != '0) begin
					nxt.bal   = lfms_pkg::sat_add(b1, lfms_pkg::D_INC1);
					nxt.phase = lfms_pkg::PH_RIGHT;
					nxt.ticks = cfg.turn_ticks - lfms_pkg::TICK_W'(1);
					cmd       = lfms_pkg::CMD_RIGHT;
				end else begin
					// empty right turn: the decide loop spins out the tick
					case (k)
						2'd0: begin
							nxt.bal   = lfms_pkg::sat_add(b1, lfms_pkg::D_INC_LOOP);
							nxt.phase = lfms_pkg::PH_DECIDE;
						end
						2'd1: begin
							nxt.bal   = lfms_pkg::sat_add(b1, lfms_pkg::D_INC_LOOP);
							nxt.phase = lfms_pkg::PH_RIGHT;
						end
						default: begin
							nxt.bal   = lfms_pkg::sat_add(b1, lfms_pkg::D_INC_LOOP_S);
							nxt.phase = lfms_pkg::PH_DECIDE;
						end
					endcase
				end
			end
		end

		// recovery turn toward the sign of a nonzero balance when turn ticks are set, then one stop tick
		if (rec) begin
			nxt.phase = lfms_pkg::PH_STOP;
			nxt.ticks = '0;
			cmd       = lfms_pkg::CMD_STOP;
			if (b1 != '0 && cfg.turn_ticks != '0) begin
				nxt.phase = b1[lfms_pkg::BAL_W-1] ? lfms_pkg::PH_REC_LEFT
				                                  : lfms_pkg::PH_REC_RIGHT;
				nxt.ticks = cfg.turn_ticks - lfms_pkg::TICK_W'(1);
				cmd       = b1[lfms_pkg::BAL_W-1] ? lfms_pkg::CMD_LEFT
				                                  : lfms_pkg::CMD_RIGHT;
			end
		end
	end

	// command outputs
	always_comb begin
		drive         = lfms_pkg::DRIVE_W'(cmd);
		motor_pattern = lfms_pkg::pattern_of(cmd);
	end

endmodule

>>> src/line_follower_motor_sequencer.sv
// line_follower_motor_sequencer: top level, input register, phase state and result register
// depends on lfms_pkg, lfms_cfg_regs and lfms_step
// an accepted transaction is held in the input register, then its command in the result register
// throughput: one transaction per cycle, limited only by m_tready
// the phase state is updated as each item moves from the input register to the result register
// reset: tick counts return to 250, 10 and 100, phase to decide, balance and counters to zero
`timescale 1ns / 1ps

module line_follower_motor_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lfms_pkg::IDX_W-1:0] cfg_index,
	input  logic [lfms_pkg::CFG_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lfms_pkg::IN_W-1:0]  s_tdata,   // sensor_left, sensor_right, zero fill
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lfms_pkg::OUT_W-1:0] m_tdata    // drive[2:0], motor_pattern[7:3]
);

	lfms_pkg::cfg_t                 cfg;
	lfms_pkg::state_t               st_q;
	lfms_pkg::state_t               st_nxt;
	logic                           vld_s1;
	logic                           sl_s1;
	logic                           sr_s1;
	logic                           vld_s2;
	logic [lfms_pkg::OUT_W-1:0]     data_s2;
	logic [lfms_pkg::DRIVE_W-1:0]   drive;
	logic [lfms_pkg::PAT_W-1:0]     motor_pattern;
	logic                           adv;

	lfms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lfms_step u_step (
		.sensor_left   (sl_s1),
		.sensor_right  (sr_s1),
		.cfg           (cfg),
		.cur           (st_q),
		.nxt           (st_nxt),
		.drive         (drive),
		.motor_pattern (motor_pattern)
	);

	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = vld_s2;
	assign m_tdata  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sl_s1 <= s_tdata[0];
			sr_s1 <= s_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {motor_pattern, drive};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase  <= lfms_pkg::PH_DECIDE;
			st_q.ticks  <= '0;
			st_q.bal    <= '0;
			st_q.resume <= 1'b0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

endmodule

>>> src/lfms_checker.sv
// lfms_checker: port-level assertions for the line follower motor sequencer, bound to the top
// depends on lfms_pkg and line_follower_motor_sequencer
`timescale 1ns / 1ps

module lfms_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [lfms_pkg::OUT_W-1:0] m_tdata
);

	logic [lfms_pkg::DRIVE_W-1:0] drv;
	logic [lfms_pkg::PAT_W-1:0]   pat;

	assign drv = m_tdata[lfms_pkg::DRIVE_W-1:0];
	assign pat = m_tdata[lfms_pkg::OUT_W-1:lfms_pkg::DRIVE_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// every accepted transaction is followed by a valid result once it can have reached the result register
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("result missing after input transaction");

	// an empty result register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// motor pattern matches the drive command
	a_pat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(drv == lfms_pkg::CMD_STOP  && pat == lfms_pkg::PAT_STOP) ||
			(drv == lfms_pkg::CMD_FWD   && pat == lfms_pkg::PAT_FWD) ||
			(drv == lfms_pkg::CMD_REV   && pat == lfms_pkg::PAT_REV) ||
			(drv == lfms_pkg::CMD_LEFT  && pat == lfms_pkg::PAT_LEFT) ||
			(drv == lfms_pkg::CMD_RIGHT && pat == lfms_pkg::PAT_RIGHT))
		else $error("motor pattern does not match drive");

endmodule

bind line_follower_motor_sequencer lfms_checker u_lfms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/lfms_tb_pkg.sv
// lfms_tb_pkg: command predictor and scoreboard class for the motor sequencer testbench
// depends on lfms_pkg for widths, phase and command enums and reset tick counts
`timescale 1ns / 1ps

package lfms_tb_pkg;

	import lfms_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam int LOOP_GUARD   = 16;

	class drive_scoreboard;

		logic [TICK_W-1:0]       lost_len;
		logic [TICK_W-1:0]       probe_len;
		logic [TICK_W-1:0]       turn_len;
		phase_t                  ph;
		logic [TICK_W-1:0]       count;
		logic signed [BAL_W-1:0] bal;
		logic                    turn_after;
		logic [OUT_W-1:0]        pending_cmds[$];
		int                      errors;

		function new();
			lost_len   = LONG_TICKS_RST;
			probe_len  = PROBE_TICKS_RST;
			turn_len   = TURN_TICKS_RST;
			ph         = PH_DECIDE;
			count      = '0;
			bal        = '0;
			turn_after = 1'b0;
			errors     = 0;
		endfunction

		function void set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
			case (idx)
				REG_LONG_TICKS:  lost_len  = val;
				REG_PROBE_TICKS: probe_len = val;
				REG_TURN_TICKS:  turn_len  = val;
				default: ;
			endcase
		endfunction

		function void begin_phase(input phase_t p, input logic [TICK_W-1:0] n);
			ph    = p;
			count = n;
		endfunction

		function void left_turn();
			if (bal != BAL_MIN) bal = bal - 1;
			turn_after = 1'b0;
			begin_phase(PH_LEFT, turn_len);
		endfunction

		// one tick of the sequencer; zero-length phases are skipped within the tick
		function cmd_t next_command(input logic l, input logic r);
			logic lost;
			cmd_t c;
			int   n;
			lost = !l && !r;
			c    = CMD_STOP;
			for (n = 0; n < LOOP_GUARD; n++) begin
				if (ph == PH_DECIDE) begin
					if (l && r) begin
						c = CMD_FWD;
						break;
					end else if (lost) begin
						turn_after = 1'b0;
						begin_phase(PH_PROBE, lost_len);
					end else if (l) begin
						turn_after = 1'b1;
						begin_phase(PH_PROBE, probe_len);
					end else begin
						if (bal != BAL_MAX) bal = bal + 1;
						begin_phase(PH_RIGHT, turn_len);
					end
					continue;
				end
				if (count != 0) begin
					count = count - 1;
					case (ph)
						PH_PROBE:               c = CMD_FWD;
						PH_REVERSE:             c = CMD_REV;
						PH_REC_LEFT, PH_LEFT:   c = CMD_LEFT;
						PH_REC_RIGHT, PH_RIGHT: c = CMD_RIGHT;
						default:                c = CMD_STOP;
					endcase
					break;
				end
				case (ph)
					PH_PROBE: begin
						if (lost) begin_phase(PH_REVERSE, lost_len);
						else if (turn_after) left_turn();
						else begin_phase(PH_DECIDE, '0);
					end
					PH_REVERSE: begin
						if (bal < 0) begin_phase(PH_REC_LEFT, turn_len);
						else if (bal > 0) begin_phase(PH_REC_RIGHT, turn_len);
						else begin_phase(PH_STOP, TICK_W'(1));
					end
					PH_REC_LEFT, PH_REC_RIGHT: begin_phase(PH_STOP, TICK_W'(1));
					PH_STOP: begin
						if (turn_after) left_turn();
						else begin_phase(PH_DECIDE, '0);
					end
					default: begin_phase(PH_DECIDE, '0);
				endcase
			end
			return c;
		endfunction

		// accepted input transaction: predict its command and pattern
		function void note_tick(input logic l, input logic r);
			cmd_t             c;
			logic [PAT_W-1:0] p;
			c = next_command(l, r);
			case (c)
				CMD_FWD:   p = PAT_FWD;
				CMD_REV:   p = PAT_REV;
				CMD_LEFT:  p = PAT_LEFT;
				CMD_RIGHT: p = PAT_RIGHT;
				default:   p = PAT_STOP;
			endcase
			pending_cmds.push_back({p, c});
		endfunction

		// accepted output transaction: compare with the oldest prediction
		function void check_command(input logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			if (pending_cmds.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result: drive %0d pattern %h",
						got[DRIVE_W-1:0], got[DRIVE_W +: PAT_W]);
				return;
			end
			want = pending_cmds.pop_front();
			if (got[DRIVE_W-1:0] !== want[DRIVE_W-1:0] ||
				got[DRIVE_W +: PAT_W] !== want[DRIVE_W +: PAT_W]) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("mismatch: expected drive %0d pattern %h, got drive %0d pattern %h",
						want[DRIVE_W-1:0], want[DRIVE_W +: PAT_W],
						got[DRIVE_W-1:0], got[DRIVE_W +: PAT_W]);
			end
		endfunction

	endclass

endpackage

>>> tb/tb_top.sv
// tb_top: self-checking testbench of line_follower_motor_sequencer, directed ticks then random
// phases under several register settings; depends on lfms_pkg and lfms_tb_pkg
`timescale 1ns / 1ps

module tb_top;

	import lfms_pkg::*;
	import lfms_tb_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [1:0] BOTH_WHITE  = 2'b00;
	localparam logic [1:0] LEFT_BLACK  = 2'b01;
	localparam logic [1:0] RIGHT_BLACK = 2'b10;
	localparam logic [1:0] BOTH_BLACK  = 2'b11;
	localparam int STALL_LIMIT   = 2000;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_TICKS   = 65;
	localparam logic [CFG_W-1:0] CFG_TOP = '1;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	drive_scoreboard board = new();
	bit idle_on = 1'b1;
	int ready_hold = 0;
	int stall_cycles = 0;

	line_follower_motor_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			ready_hold <= $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_command(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic send_tick(input logic [1:0] pair);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-2){1'b0}}, pair};
		do @(posedge clk); while (!s_tready);
		board.note_tick(pair[0], pair[1]);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic set_ticks(input logic [CFG_W-1:0] lt, input logic [CFG_W-1:0] pt,
			input logic [CFG_W-1:0] tt);
		write_reg(REG_LONG_TICKS, lt);
		write_reg(REG_PROBE_TICKS, pt);
		write_reg(REG_TURN_TICKS, tt);
		write_reg(REG_SPARE, CFG_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic wait_for_commands();
		s_tvalid <= 1'b0;
		while (board.pending_cmds.size() != 0) @(negedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_ticks();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r < 8) return CFG_W'($urandom_range(1, 6));
		return CFG_W'($urandom_range(7, 300));
	endfunction

	function automatic logic [1:0] pick_sensors();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return BOTH_WHITE;
		if (r < 60) return LEFT_BLACK;
		if (r < 80) return RIGHT_BLACK;
		return BOTH_BLACK;
	endfunction

	initial begin
		logic [1:0] at_reset[$];
		logic [1:0] short_runs[$];
		logic [1:0] zero_runs[$];
		int p;
		int k;
		at_reset = '{BOTH_BLACK, BOTH_BLACK, RIGHT_BLACK, BOTH_WHITE};
		short_runs = '{BOTH_BLACK, LEFT_BLACK, LEFT_BLACK, BOTH_BLACK, LEFT_BLACK,
			BOTH_WHITE, BOTH_WHITE, BOTH_WHITE, BOTH_WHITE, BOTH_WHITE, BOTH_WHITE,
			BOTH_WHITE, BOTH_WHITE, RIGHT_BLACK, RIGHT_BLACK, BOTH_WHITE};
		zero_runs = '{LEFT_BLACK, RIGHT_BLACK, BOTH_WHITE, BOTH_BLACK};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset tick counts, then short runs, then zero-length phases
		foreach (at_reset[i]) send_tick(at_reset[i]);
		wait_for_commands();
		set_ticks(16'd2, 16'd1, 16'd1);
		foreach (short_runs[i]) send_tick(short_runs[i]);
		wait_for_commands();
		set_ticks('0, '0, '0);
		foreach (zero_runs[i]) send_tick(zero_runs[i]);
		wait_for_commands();

		for (p = 0; p < RAND_PHASES; p++) begin
			idle_on = (p == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			if (p == 2) set_ticks(CFG_TOP, CFG_TOP, CFG_TOP);
			else if (p == 3) set_ticks(16'd1, 16'd1, 16'd1);
			else set_ticks(pick_ticks(), pick_ticks(), pick_ticks());
			for (k = 0; k < PHASE_TICKS; k++) send_tick(pick_sensors());
			wait_for_commands();
		end

		repeat (8) @(negedge clk);
		if (board.errors == 0 && board.pending_cmds.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
